// File: design/bqlp_pkg.sv
`default_nettype none

package bqlp_pkg;

   localparam int unsigned ADC_BITS_DEF = 12;
   localparam int unsigned DAC_BITS_DEF = 14;

   localparam int unsigned COEF_W   = 32;
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned PROD_W   = 2 * COEF_W;
   localparam int unsigned ACC_W    = PROD_W + 3;
   localparam int unsigned CSR_IDX_W = 3;

   localparam int unsigned COEF_FRAC   = 30;
   localparam int unsigned SAMPLE_FRAC = 28;

   localparam logic signed [SAMPLE_W-1:0] HALF_Q28 = 32'sd268435456;
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX  = 32'sh7fffffff;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN  = 32'sh80000000;

   localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd65506;
   localparam logic signed [COEF_W-1:0] B1_RESET = 32'sd131012;
   localparam logic signed [COEF_W-1:0] B2_RESET = 32'sd65506;
   localparam logic signed [COEF_W-1:0] A1_RESET = -32'sd2123632058;
   localparam logic signed [COEF_W-1:0] A2_RESET = 32'sd1050152152;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

// File: design/bqlp_if.sv
`default_nettype none

interface bqlp_req_if #(
   parameter int unsigned ADC_BITS = bqlp_pkg::ADC_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface

interface bqlp_rsp_if #(
   parameter int unsigned DAC_BITS = bqlp_pkg::DAC_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [DAC_BITS-1:0] dac_word;
   logic                clipped;

   modport source (output valid, output dac_word, output clipped, input ready);
   modport sink   (input valid, input dac_word, input clipped, output ready);
endinterface

`default_nettype wire

// File: design/bqlp_adc_map.sv
`default_nettype none

module bqlp_adc_map #(
   parameter int unsigned ADC_BITS = bqlp_pkg::ADC_BITS_DEF
) (
   input  wire logic [ADC_BITS-1:0]                  adc_code,
   output logic signed [bqlp_pkg::SAMPLE_W-1:0]      sample
);
   import bqlp_pkg::*;

   localparam int unsigned GUARD = ADC_BITS + 5;
   localparam int unsigned SHW   = SAMPLE_FRAC + GUARD;
   localparam int unsigned MW    = SHW + ADC_BITS;
   localparam int unsigned NTERM = (SHW + ADC_BITS) / ADC_BITS;
   localparam int unsigned SW    = SHW + 2;
   localparam logic [ADC_BITS:0] AMAX_W = {1'b0, {ADC_BITS{1'b1}}};

   logic [ADC_BITS:0]   twice;
   logic                neg;
   logic [ADC_BITS-1:0] mag_in;
   logic [MW-1:0]       wide;
   logic [SW-1:0]       sum;
   logic [SW-1:0]       rnd;
   logic [SAMPLE_FRAC:0] mag;

   // divide by 2^A-1 as the series 2^-A + 2^-2A + ..., truncated from below
   always_comb begin
      twice  = {adc_code, 1'b0};
      neg    = twice < AMAX_W;
      mag_in = neg ? ADC_BITS'(AMAX_W - twice) : ADC_BITS'(twice - AMAX_W);
      wide   = {mag_in, {SHW{1'b0}}};
      sum    = '0;
      for (int k = 1; k <= NTERM; k++) begin
         sum = sum + SW'(wide >> (k * ADC_BITS));
      end
      rnd = sum + (SW'(1) << (GUARD - 1));
      mag = (SAMPLE_FRAC + 1)'(rnd >> GUARD);
      if (neg) begin
         sample = SAMPLE_W'(0) - SAMPLE_W'(mag);
      end else begin
         sample = SAMPLE_W'(mag);
      end
   end

endmodule

`default_nettype wire

// File: design/bqlp_dac_map.sv
`default_nettype none

module bqlp_dac_map #(
   parameter int unsigned DAC_BITS = bqlp_pkg::DAC_BITS_DEF
) (
   input  wire logic signed [bqlp_pkg::SAMPLE_W-1:0] sample,
   output logic [DAC_BITS-1:0]                       dac_word,
   output logic                                      clipped
);
   import bqlp_pkg::*;

   localparam int unsigned NW = SAMPLE_W + 1 + DAC_BITS + 2;
   localparam int unsigned SH = SAMPLE_FRAC + 1;
   localparam logic [NW-SH-2:0] DMAX_N = (NW-SH-1)'((2 ** DAC_BITS) - 1);
   localparam logic signed [NW-1:0] HALF_N = NW'(HALF_Q28);

   logic signed [SAMPLE_W:0] shifted;
   logic signed [NW-1:0]     te;
   logic signed [NW-1:0]     n;

   // code = floor(((y + 2^28) * DMAX + 2^28) / 2^29) for raw Q4.28 y, saturated
   always_comb begin
      shifted = $signed({sample[SAMPLE_W-1], sample}) + $signed({1'b0, HALF_Q28});
      te      = NW'(shifted);
      n       = (te <<< DAC_BITS) - te + HALF_N;
      if (n[NW-1]) begin
         dac_word = '0;
         clipped  = 1'b1;
      end else if (n[NW-2:SH] > DMAX_N) begin
         dac_word = '1;
         clipped  = 1'b1;
      end else begin
         dac_word = n[SH +: DAC_BITS];
         clipped  = 1'b0;
      end
   end

endmodule

`default_nettype wire

// File: design/biquad_lowpass_adc_to_dac.sv
// Second-order low-pass filter between a unipolar ADC and a unipolar DAC.
// req_if carries one converter code per beat (valid/ready); rsp_if returns
// one DAC code and a clip flag per beat, in order.
// The code maps to a signed Q4.28 sample, runs through a direct-form-1
// biquad with Q2.30 coefficients b0, b1, b2, a1, a2, and maps back to a
// rounded DAC code, saturated to zero or full scale with clipped set.
// Coefficients are written through csr_we/csr_index/csr_wdata; the user
// must write them only while no beat is in flight, and the block itself
// does nothing to enforce this; indexes past a2 are ignored. Throughput: one
// beat per cycle while the receiver takes each beat; the loop through a1/a2,
// the feedback multipliers and the accumulator closes through yd1/yd2 alone.
// Each of the six stages holds its beat only while the stage after it is
// full and stalled, so req_ready stays high while any stage is empty.
// A stalled receiver backs up the stages one by one; req_ready drops only
// when all six hold a beat.
// Reset loads the default coefficients, clears the sample history and
// empties the pipeline.
`default_nettype none

module biquad_lowpass_adc_to_dac #(
   parameter int unsigned ADC_BITS = bqlp_pkg::ADC_BITS_DEF,
   parameter int unsigned DAC_BITS = bqlp_pkg::DAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bqlp_req_if.sink                               req_if,
   bqlp_rsp_if.source                             rsp_if,
   input  wire logic                              csr_we,
   input  wire logic [bqlp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bqlp_pkg::COEF_W-1:0]       csr_wdata
);
   import bqlp_pkg::*;

   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   logic [ADC_BITS-1:0]        code_ff;
   logic signed [SAMPLE_W-1:0] x_in, x_ff;
   logic signed [SAMPLE_W-1:0] xd1_ff, xd2_ff;
   logic signed [PROD_W-1:0]   p0_in, p1_in, p2_in;
   logic signed [PROD_W-1:0]   p0_ff, p1_ff, p2_ff;
   logic signed [ACC_W-1:0]    ffsum_in, ffsum_ff;
   logic signed [PROD_W-1:0]   fb1, fb2;
   logic signed [ACC_W-1:0]    acc;
   logic signed [ACC_W-COEF_FRAC-1:0] yq;
   logic signed [SAMPLE_W-1:0] y_in;
   logic signed [SAMPLE_W-1:0] yd1_ff, yd2_ff;
   logic [DAC_BITS-1:0]        dac_in, dac_ff;
   logic                       clip_in, clip_ff;

   assign en6 = !v6_ff || rsp_if.ready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_if.ready    = en1;
   assign rsp_if.valid    = v6_ff;
   assign rsp_if.dac_word = dac_ff;
   assign rsp_if.clipped  = clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= B0_RESET;
         b1_ff <= B1_RESET;
         b2_ff <= B2_RESET;
         a1_ff <= A1_RESET;
         a2_ff <= A2_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_B0: b0_ff <= csr_wdata;
            CSR_B1: b1_ff <= csr_wdata;
            CSR_B2: b2_ff <= csr_wdata;
            CSR_A1: a1_ff <= csr_wdata;
            CSR_A2: a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_if.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   bqlp_adc_map #(.ADC_BITS(ADC_BITS)) u_adc_map (
      .adc_code (code_ff),
      .sample   (x_in)
   );

   always_comb begin
      p0_in    = PROD_W'(b0_ff) * PROD_W'(x_ff);
      p1_in    = PROD_W'(b1_ff) * PROD_W'(xd1_ff);
      p2_in    = PROD_W'(b2_ff) * PROD_W'(xd2_ff);
      ffsum_in = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff);
   end

   // feedback loop: closes through yd1/yd2 alone
   always_comb begin
      fb1 = PROD_W'(a1_ff) * PROD_W'(yd1_ff);
      fb2 = PROD_W'(a2_ff) * PROD_W'(yd2_ff);
      acc = ffsum_ff - ACC_W'(fb1) - ACC_W'(fb2)
            + (ACC_W'(1) <<< (COEF_FRAC - 1));
      yq  = acc[ACC_W-1:COEF_FRAC];
      if (yq[ACC_W-COEF_FRAC-1:SAMPLE_W-1] == '0
          || yq[ACC_W-COEF_FRAC-1:SAMPLE_W-1] == '1) begin
         y_in = yq[SAMPLE_W-1:0];
      end else if (yq[ACC_W-COEF_FRAC-1]) begin
         y_in = SAT_MIN;
      end else begin
         y_in = SAT_MAX;
      end
   end

   bqlp_dac_map #(.DAC_BITS(DAC_BITS)) u_dac_map (
      .sample   (yd1_ff),
      .dac_word (dac_in),
      .clipped  (clip_in)
   );

   always_ff @(posedge clock) begin
      if (en1) code_ff <= req_if.adc_code;
      if (en2) x_ff <= x_in;
      if (en3) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (en4) ffsum_ff <= ffsum_in;
      if (en6) begin
         dac_ff  <= dac_in;
         clip_ff <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xd1_ff <= '0;
         xd2_ff <= '0;
         yd1_ff <= '0;
         yd2_ff <= '0;
      end else begin
         if (en3 && v2_ff) begin
            xd1_ff <= x_ff;
            xd2_ff <= xd1_ff;
         end
         if (en5 && v4_ff) begin
            yd1_ff <= y_in;
            yd2_ff <= yd1_ff;
         end
      end
   end

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && clip_ff) |-> (dac_ff == '0 || dac_ff == '1))
      else $error("clipped beat not at a rail");

   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff
                         && !rsp_if.ready))
      else $error("ready dropped with an empty stage");

   a_y_history: assert property (@(posedge clock) disable iff (reset)
      (en5 && v4_ff) |=> (yd2_ff == $past(yd1_ff)))
      else $error("output history did not advance");

   a_x_history: assert property (@(posedge clock) disable iff (reset)
      (en3 && v2_ff) |=> (xd1_ff == $past(x_ff) && xd2_ff == $past(xd1_ff)))
      else $error("input history did not advance");

endmodule

`default_nettype wire

// File: bench/biquad_lowpass_adc_to_dac_tb.sv
`timescale 1ns / 1ps

module biquad_lowpass_adc_to_dac_tb;
   import bqlp_pkg::*;

   localparam int unsigned ADC_W = ADC_BITS_DEF;
   localparam int unsigned DAC_W = DAC_BITS_DEF;
   localparam longint ADC_FULL = (longint'(1) << ADC_W) - 1;
   localparam longint DAC_FULL = (longint'(1) << DAC_W) - 1;
   localparam longint ONE_Q28 = longint'(1) << SAMPLE_FRAC;
   localparam logic signed [ACC_W-1:0] ROUND_Q30 = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fffffff;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh80000000;
   localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh40000000;
   localparam int CSR_COUNT = int'(CSR_A2) + 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_IDX_W'(CSR_COUNT);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST = '1;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_BEATS = 175;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [DAC_W-1:0] dac_word;
      logic             clipped;
   } dac_beat_type;

   typedef enum bit {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [COEF_W-1:0]      wdata;
      logic [ADC_W-1:0]       code;
      bit                     pinned;
      logic [DAC_W-1:0]       dac;
      logic                   clip;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0] csr_wdata;

   bqlp_req_if req_if ();
   bqlp_rsp_if rsp_if ();

   biquad_lowpass_adc_to_dac i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic signed [COEF_W-1:0] coef_q30 [CSR_COUNT];
   logic signed [SAMPLE_W-1:0] x_hist1, x_hist2, y_hist1, y_hist2;
   dac_beat_type dac_expect_q [$];

   logic pin_valid;
   logic [DAC_W-1:0] pin_dac;
   logic pin_clip;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int hold_served;
   int hold_left;
   int fault_count;
   int beats_in;
   int beats_out;
   int clip_count;
   int input_stalls;
   int csr_writes;

   stim_row_type directed_rows [$];

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic signed [SAMPLE_W-1:0] code_to_q28(logic [ADC_W-1:0] code);
      longint twice, span, mag;
      twice = 2 * longint'(code);
      span = (twice < ADC_FULL) ? ADC_FULL - twice : twice - ADC_FULL;
      mag = (span * 2 * ONE_Q28 + ADC_FULL) / (2 * ADC_FULL);
      return SAMPLE_W'((twice < ADC_FULL) ? -mag : mag);
   endfunction

   function automatic dac_beat_type filter_step(logic [ADC_W-1:0] code);
      logic signed [SAMPLE_W-1:0] x;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] yw;
      logic signed [SAMPLE_W-1:0] ysat;
      longint n;
      dac_beat_type r;
      x = code_to_q28(code);
      acc = ACC_W'(coef_q30[CSR_B0]) * ACC_W'(x)
          + ACC_W'(coef_q30[CSR_B1]) * ACC_W'(x_hist1)
          + ACC_W'(coef_q30[CSR_B2]) * ACC_W'(x_hist2)
          - ACC_W'(coef_q30[CSR_A1]) * ACC_W'(y_hist1)
          - ACC_W'(coef_q30[CSR_A2]) * ACC_W'(y_hist2) + ROUND_Q30;
      yw = acc >>> COEF_FRAC;
      if (yw > SAT_MAX) begin
         ysat = SAT_MAX;
      end else if (yw < SAT_MIN) begin
         ysat = SAT_MIN;
      end else begin
         ysat = SAMPLE_W'(yw);
      end
      x_hist2 = x_hist1;
      x_hist1 = x;
      y_hist2 = y_hist1;
      y_hist1 = ysat;
      n = (longint'(ysat) + ONE_Q28) * DAC_FULL + ONE_Q28;
      if (n < 0) begin
         r.dac_word = '0;
         r.clipped = 1'b1;
      end else begin
         n = n / (2 * ONE_Q28);
         r.clipped = (n > DAC_FULL);
         r.dac_word = r.clipped ? DAC_W'(DAC_FULL) : DAC_W'(n);
      end
      return r;
   endfunction

   function automatic logic [COEF_W-1:0] reset_coef(csr_index_type idx);
      case (idx)
         CSR_B0: return B0_RESET;
         CSR_B1: return B1_RESET;
         CSR_B2: return B2_RESET;
         CSR_A1: return A1_RESET;
         default: return A2_RESET;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] phase_coef(int phase, csr_index_type idx);
      logic signed [COEF_W-1:0] raw;
      raw = $signed($urandom);
      case (phase)
         1: begin
            if (idx == CSR_A1) return raw >>> 1;
            if (idx == CSR_A2) return raw >>> 2;
            return raw >>> 3;
         end
         2: return (idx == CSR_A1 || idx == CSR_A2) ? '0 : raw >>> 2;
         3: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
         4: return raw;
         default: return reset_coef(idx);
      endcase
   endfunction

   function automatic logic [ADC_W-1:0] pick_code();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return ADC_W'($urandom);
      endcase
   endfunction

   function automatic stim_row_type beat_row(logic [ADC_W-1:0] code, bit pinned = 1'b0,
                                             logic [DAC_W-1:0] dac = '0, logic clip = 1'b0);
      stim_row_type r;
      r = '0;
      r.kind = ROW_BEAT;
      r.code = code;
      r.pinned = pinned;
      r.dac = dac;
      r.clip = clip;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.index = idx;
      r.wdata = data;
      return r;
   endfunction

   task automatic send_beat(logic [ADC_W-1:0] code, bit pinned, logic [DAC_W-1:0] dac,
                            logic clip);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.adc_code <= code;
      pin_valid <= pinned;
      pin_dac <= dac;
      pin_clip <= clip;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      req_if.valid <= 1'b0;
      while (dac_expect_q.size() != 0) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      csr_writes++;
   endtask

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      dac_beat_type want;
      dac_beat_type got;
      if (reset) begin
         for (int k = 0; k < CSR_COUNT; k++) coef_q30[k] = reset_coef(csr_index_type'(k));
         x_hist1 = '0;
         x_hist2 = '0;
         y_hist1 = '0;
         y_hist2 = '0;
      end else begin
         if (csr_we && csr_index <= CSR_A2) coef_q30[csr_index] = csr_wdata;
         if (req_if.valid && !req_if.ready) input_stalls++;
         if (req_if.valid && req_if.ready) begin
            want = filter_step(req_if.adc_code);
            if (pin_valid) begin
               want.dac_word = pin_dac;
               want.clipped = pin_clip;
            end
            dac_expect_q.push_back(want);
            beats_in++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.dac_word = rsp_if.dac_word;
            got.clipped = rsp_if.clipped;
            beats_out++;
            if (got.clipped) clip_count++;
            if (dac_expect_q.size() == 0) begin
               $display("%0t: unexpected beat, dac_word %0d clipped %0b", $time,
                        got.dac_word, got.clipped);
               fault_count++;
            end else begin
               want = dac_expect_q.pop_front();
               if (got.dac_word !== want.dac_word) begin
                  $display("%0t: dac_word expected %0d, got %0d", $time,
                           want.dac_word, got.dac_word);
                  fault_count++;
               end
               if (got.clipped !== want.clipped) begin
                  $display("%0t: clipped expected %0b, got %0b", $time,
                           want.clipped, got.clipped);
                  fault_count++;
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.adc_code = '0;
      rsp_if.ready = 1'b0;
      pin_valid = 1'b0;
      pin_dac = '0;
      pin_clip = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 0;
      hold_served = 0;
      hold_left = 0;
      fault_count = 0;
      beats_in = 0;
      beats_out = 0;
      clip_count = 0;
      input_stalls = 0;
      csr_writes = 0;

      directed_rows = '{
         beat_row(12'd0, 1'b1, 14'd8191, 1'b0),
         beat_row(12'd4095), beat_row(12'd2047), beat_row(12'd2048),
         beat_row(12'h555), beat_row(12'haaa),
         // unity pass-through
         csr_row(CSR_B0, COEF_ONE), csr_row(CSR_B1, '0), csr_row(CSR_B2, '0),
         csr_row(CSR_A1, '0), csr_row(CSR_A2, '0),
         beat_row(12'd0, 1'b1, 14'd0, 1'b0),
         beat_row(12'd4095, 1'b1, DAC_W'(DAC_FULL), 1'b0),
         beat_row(12'd2048), beat_row(12'd2047),
         // gain near two: clip both rails
         csr_row(CSR_B0, COEF_MAX),
         beat_row(12'd4095, 1'b1, DAC_W'(DAC_FULL), 1'b1),
         beat_row(12'd0, 1'b1, 14'd0, 1'b1),
         // spare indexes must leave the coefficients alone
         csr_row(CSR_SPARE_FIRST, '0), csr_row(CSR_SPARE_LAST, 32'h12345678),
         beat_row(12'd4095, 1'b1, DAC_W'(DAC_FULL), 1'b1),
         // runaway feedback: drive the accumulator into both limits
         csr_row(CSR_A1, COEF_MIN),
         beat_row(12'd4095), beat_row(12'd4095), beat_row(12'd4095),
         csr_row(CSR_B0, COEF_MIN), csr_row(CSR_A1, COEF_MAX),
         beat_row(12'd4095), beat_row(12'd4095)
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            csr_write(directed_rows[r].index, directed_rows[r].wdata);
         end else begin
            send_beat(directed_rows[r].code, directed_rows[r].pinned,
                      directed_rows[r].dac, directed_rows[r].clip);
         end
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p < 2) begin
            send_idle_pct = 38;
            recv_idle_pct = 67;
         end else if (p < 4) begin
            send_idle_pct = 67;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int k = 0; k < CSR_COUNT; k++) begin
            csr_write(CSR_IDX_W'(k), phase_coef(p, csr_index_type'(k)));
         end
         if (p == RAND_PHASES - 1) begin
            csr_write(CSR_SPARE_FIRST, $urandom);
            csr_write(CSR_SPARE_LAST, $urandom);
         end
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (p == 4 && i == 40) hold_requests++;
            send_beat(pick_code(), 1'b0, '0, 1'b0);
         end
      end

      req_if.valid <= 1'b0;
      while (dac_expect_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (dac_expect_q.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, dac_expect_q.size());
         fault_count++;
      end
      $display("Filtered %0d samples, %0d returned (%0d clipped), %0d coefficient writes",
               beats_in, beats_out, clip_count, csr_writes);
      $display("Input held off %0d cycles by a backed-up output", input_stalls);
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
